// ----- src/mrpt_pkg.sv -----
`timescale 1ns / 1ps
package mrpt_pkg;

   localparam int MOD_WIDTH_DEF   = 82;
   localparam int SMALL_LIMIT_DEF = 1000000;
   localparam int NUM_BASES       = 7;
   localparam int BASE_WIDTH      = 31;
   localparam int N_WIDTH         = 82;
   localparam int REQ_DATA_WIDTH  = 88;
   localparam int RSP_DATA_WIDTH  = 8;

   localparam logic [N_WIDTH-1:0] DET_BOUND = {18'h2be69, 64'h51adc5b22410a5fd};

   localparam logic [BASE_WIDTH-1:0] TEST_BASES [NUM_BASES] = '{
      31'd2, 31'd325, 31'd9375, 31'd28178, 31'd450775, 31'd9780504, 31'd1795265022
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECOMP,
      ST_BASE_SEL,
      ST_RED,
      ST_RED_END,
      ST_EXP_BIT,
      ST_EXP_SQD,
      ST_EXP_NEXT,
      ST_CHECK,
      ST_SQ_TEST,
      ST_SQ_CHK,
      ST_BASE_NEXT,
      ST_MUL_DBL,
      ST_MUL_ADD
   } state_type;

endpackage

// ----- src/miller_rabin_primality_test.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Transfer               Payload
// req_      in   req_tvalid&req_tready  tdata[17:0] n_high, tdata[81:18] n_low
// rsp_      out  rsp_tvalid&rsp_tready  tdata[0] is_prime, tdata[1] out_of_range
//
// Zero, one, even and out-of-range numbers answer in the cycle after the transfer.
// Other numbers run strong-probable-prime rounds on one shared modular adder:
// a round is at most 2*MOD_WIDTH modular multiplies, with up to seven rounds.
// Reset is synchronous, active high; req_tready stays low while busy and while
// a result waits on rsp_.
module miller_rabin_primality_test #(
   parameter int MOD_WIDTH   = mrpt_pkg::MOD_WIDTH_DEF,
   parameter int SMALL_LIMIT = mrpt_pkg::SMALL_LIMIT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mrpt_pkg::REQ_DATA_WIDTH-1:0] req_tdata,  // n_high[17:0], n_low[81:18]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mrpt_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata   // is_prime[0], out_of_range[1]
);
   import mrpt_pkg::*;

   localparam int CW = $clog2(MOD_WIDTH);
   localparam logic [CW-1:0] TOP_BIT = CW'(MOD_WIDTH - 1);
   localparam logic [CW-1:0] BASE_TOP = CW'(BASE_WIDTH - 1);
   localparam logic [2:0] LAST_BASE = 3'(NUM_BASES - 1);

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [MOD_WIDTH-1:0] n_ff, n_in, nm1_ff, nm1_in, d_ff, d_in;
   logic [MOD_WIDTH-1:0] a_ff, a_in, x_ff, x_in, ma_ff, ma_in, mb_ff, mb_in, acc_ff, acc_in;
   logic [CW-1:0] s_ff, s_in, r_ff, r_in, i_ff, i_in, j_ff, j_in;
   logic [2:0] k_ff, k_in;
   logic small_ff, small_in;
   logic rsp_valid_ff, rsp_valid_in, prime_ff, prime_in, oor_ff, oor_in;

   logic [N_WIDTH-1:0] req_n;
   logic [MOD_WIDTH-1:0] req_nw, one_w, base_w, op_p, op_q;
   logic op_c;
   logic [MOD_WIDTH:0] sum_raw, sum_sub;
   logic [MOD_WIDTH-1:0] u_sum;
   logic [BASE_WIDTH-1:0] base_cur;
   logic accept, req_small, req_trivial;

   assign req_n    = {req_tdata[17:0], req_tdata[N_WIDTH-1:18]};
   assign req_nw   = MOD_WIDTH'(req_n);
   assign one_w    = MOD_WIDTH'(1);
   assign base_cur = TEST_BASES[k_ff];
   assign base_w   = MOD_WIDTH'(base_cur);

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, oor_ff, prime_ff};

   assign req_small   = (req_n[81:64] == 18'd0) && (req_n[63:0] <= 64'(SMALL_LIMIT));
   assign req_trivial = req_small ? (req_n[63:0] < 64'd3 || !req_n[0])
                                  : (!req_n[0] || req_n >= DET_BOUND);

   always_comb begin
      op_p = acc_ff;
      op_q = acc_ff;
      op_c = 1'b0;
      if (state_ff == ST_RED) begin
         op_c = base_cur[i_ff[4:0]];
      end else if (state_ff == ST_MUL_ADD) begin
         op_q = ma_ff;
      end
   end

   assign sum_raw = {1'b0, op_p} + {1'b0, op_q} + (MOD_WIDTH+1)'(op_c);
   assign sum_sub = sum_raw - {1'b0, n_ff};
   assign u_sum   = (sum_raw >= {1'b0, n_ff}) ? sum_sub[MOD_WIDTH-1:0]
                                              : sum_raw[MOD_WIDTH-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (accept && !req_trivial) state_in = ST_DECOMP;
         ST_DECOMP:    if (d_ff[0]) state_in = ST_BASE_SEL;
         ST_BASE_SEL: begin
            if (small_ff) state_in = ST_RED;
            else if (base_w >= n_ff) state_in = ST_BASE_NEXT;
            else state_in = ST_EXP_BIT;
         end
         ST_RED:       if (i_ff == '0) state_in = ST_RED_END;
         ST_RED_END:   state_in = (acc_ff == '0) ? ST_BASE_NEXT : ST_EXP_BIT;
         ST_EXP_BIT:   state_in = ST_MUL_DBL;
         ST_EXP_SQD:   state_in = d_ff[j_ff] ? ST_MUL_DBL : ST_EXP_NEXT;
         ST_EXP_NEXT:  state_in = (j_ff == '0) ? ST_CHECK : ST_EXP_BIT;
         ST_CHECK:     state_in = (x_ff == one_w || x_ff == nm1_ff) ? ST_BASE_NEXT
                                                                    : ST_SQ_TEST;
         ST_SQ_TEST:   state_in = (r_ff >= s_ff) ? ST_IDLE : ST_MUL_DBL;
         ST_SQ_CHK:    state_in = (x_ff == nm1_ff) ? ST_BASE_NEXT : ST_SQ_TEST;
         ST_BASE_NEXT: state_in = (k_ff == LAST_BASE) ? ST_IDLE : ST_BASE_SEL;
         ST_MUL_DBL:   state_in = ST_MUL_ADD;
         ST_MUL_ADD:   state_in = (i_ff == '0) ? ret_ff : ST_MUL_DBL;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      n_in = n_ff; nm1_in = nm1_ff; d_in = d_ff; a_in = a_ff; x_in = x_ff;
      ma_in = ma_ff; mb_in = mb_ff; acc_in = acc_ff; s_in = s_ff; r_in = r_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; small_in = small_ff; ret_in = ret_ff;
      rsp_valid_in = rsp_valid_ff; prime_in = prime_ff; oor_in = oor_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in     = req_nw;
               nm1_in   = req_nw - one_w;
               d_in     = req_nw - one_w;
               s_in     = '0;
               k_in     = '0;
               small_in = req_small;
               if (req_trivial) begin
                  rsp_valid_in = 1'b1;
                  prime_in     = req_small && (req_n[63:0] == 64'd2);
                  oor_in       = !req_small && req_n[0];
               end
            end
         end
         ST_DECOMP: begin
            if (!d_ff[0]) begin
               d_in = d_ff >> 1;
               s_in = s_ff + 1'b1;
            end
         end
         ST_BASE_SEL: begin
            acc_in = '0;
            i_in   = BASE_TOP;
            a_in   = base_w;
            x_in   = one_w;
            j_in   = TOP_BIT;
         end
         ST_RED: begin
            acc_in = u_sum;
            i_in   = i_ff - 1'b1;
         end
         ST_RED_END: begin
            a_in = acc_ff;
            x_in = one_w;
            j_in = TOP_BIT;
         end
         ST_EXP_BIT: begin
            ma_in = x_ff; mb_in = x_ff; acc_in = '0; i_in = TOP_BIT; ret_in = ST_EXP_SQD;
         end
         ST_EXP_SQD: begin
            ma_in = x_ff; mb_in = a_ff; acc_in = '0; i_in = TOP_BIT; ret_in = ST_EXP_NEXT;
         end
         ST_EXP_NEXT: j_in = j_ff - 1'b1;
         ST_CHECK:    r_in = CW'(1);
         ST_SQ_TEST: begin
            if (r_ff >= s_ff) begin
               rsp_valid_in = 1'b1;
               prime_in     = 1'b0;
               oor_in       = 1'b0;
            end
            ma_in = x_ff; mb_in = x_ff; acc_in = '0; i_in = TOP_BIT; ret_in = ST_SQ_CHK;
         end
         ST_SQ_CHK:   r_in = r_ff + 1'b1;
         ST_BASE_NEXT: begin
            k_in = k_ff + 1'b1;
            if (k_ff == LAST_BASE) begin
               rsp_valid_in = 1'b1;
               prime_in     = 1'b1;
               oor_in       = 1'b0;
            end
         end
         ST_MUL_DBL:  acc_in = u_sum;
         ST_MUL_ADD: begin
            if (mb_ff[i_ff]) acc_in = u_sum;
            i_in = i_ff - 1'b1;
            if (i_ff == '0) x_in = mb_ff[i_ff] ? u_sum : acc_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; nm1_ff <= nm1_in; d_ff <= d_in; a_ff <= a_in; x_ff <= x_in;
      ma_ff <= ma_in; mb_ff <= mb_in; acc_ff <= acc_in; s_ff <= s_in; r_ff <= r_in;
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; small_ff <= small_in; ret_ff <= ret_in;
      prime_ff <= prime_in; oor_ff <= oor_in;
   end

endmodule

// ----- src/mrpt_checker.sv -----
`timescale 1ns / 1ps
module mrpt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [mrpt_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import mrpt_pkg::*;

   hold_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after a transfer");

   one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("ready while a result waits");

   oor_not_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("out_of_range with is_prime");

endmodule

bind miller_rabin_primality_test mrpt_checker u_mrpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- verif/tb_miller_rabin_primality_test.sv -----
`timescale 1ns / 1ps
module tb_miller_rabin_primality_test;
   import mrpt_pkg::*;

   typedef struct packed {
      logic out_of_range;
      logic is_prime;
   } verdict_type;

   localparam int IDLE_LIMIT = 1500000;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   logic [REQ_DATA_WIDTH-1:0] pending_numbers[$];
   verdict_type               expected_verdicts[$];
   int                        errors = 0;
   int                        numbers_sent = 0;
   int                        verdicts_seen = 0;
   int                        primes_seen = 0;
   int                        out_of_range_seen = 0;
   int                        idle_cycles = 0;
   bit                        req_taken = 0;
   bit                        rsp_hold = 0;

   miller_rabin_primality_test dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),  // n_high[17:0], n_low[81:18]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)   // is_prime[0], out_of_range[1]
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic [N_WIDTH-1:0] mul_mod(logic [N_WIDTH-1:0] a, logic [N_WIDTH-1:0] b,
                                                  logic [N_WIDTH-1:0] m);
      logic [2*N_WIDTH-1:0] prod;
      prod = {{N_WIDTH{1'b0}}, a} * {{N_WIDTH{1'b0}}, b};
      prod = prod % {{N_WIDTH{1'b0}}, m};
      return prod[N_WIDTH-1:0];
   endfunction

   function automatic bit passes_round(logic [N_WIDTH-1:0] n, logic [N_WIDTH-1:0] d, int s,
                                       logic [N_WIDTH-1:0] a);
      logic [N_WIDTH-1:0] x;
      logic [N_WIDTH-1:0] b;
      logic [N_WIDTH-1:0] e;
      x = 1;
      b = a;
      e = d;
      while (e != 0) begin
         if (e[0]) x = mul_mod(x, b, n);
         b = mul_mod(b, b, n);
         e = e >> 1;
      end
      if (x == 1 || x == n - 1) return 1'b1;
      for (int i = 1; i < s; i++) begin
         x = mul_mod(x, x, n);
         if (x == n - 1) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic verdict_type predict_primality(logic [REQ_DATA_WIDTH-1:0] word);
      verdict_type        v;
      logic [N_WIDTH-1:0] n;
      logic [N_WIDTH-1:0] d;
      int                 s;
      v = '0;
      n = {word[17:0], word[N_WIDTH-1:18]};
      if (n <= SMALL_LIMIT_DEF) begin
         v.is_prime = (n >= 2);
         for (longint p = 2; p * p <= n; p++) begin
            if (n % p == 0) begin
               v.is_prime = 1'b0;
               break;
            end
         end
         return v;
      end
      if (!n[0]) return v;
      if (n >= DET_BOUND) begin
         v.out_of_range = 1'b1;
         return v;
      end
      d = n - 1;
      s = 0;
      while (!d[0]) begin
         d = d >> 1;
         s++;
      end
      v.is_prime = 1'b1;
      for (int k = 0; k < NUM_BASES; k++) begin
         if (N_WIDTH'(TEST_BASES[k]) >= n) continue;
         if (!passes_round(n, d, s, N_WIDTH'(TEST_BASES[k]))) begin
            v.is_prime = 1'b0;
            break;
         end
      end
      return v;
   endfunction

   function automatic logic [REQ_DATA_WIDTH-1:0] pack_number(logic [17:0] hi, logic [63:0] lo);
      return {6'b0, lo, hi};
   endfunction

   function automatic logic [REQ_DATA_WIDTH-1:0] random_number();
      logic [17:0] hi;
      logic [63:0] lo;
      int          pick;
      pick = $urandom_range(99);
      lo = {$urandom, $urandom};
      if (pick < 20) begin
         lo[0] = 1'b0;
         return pack_number(18'($urandom), lo);
      end
      if (pick < 30) begin
         lo[0] = 1'b1;
         hi = 18'($urandom_range(18'h3ffff, 18'h2be6a));
         return pack_number(hi, lo);
      end
      if (pick < 35) return pack_number(18'd0, 64'($urandom_range(SMALL_LIMIT_DEF)));
      if (pick < 60) return pack_number(18'd0, 64'($urandom_range(SMALL_LIMIT_DEF, 3) | 1));
      if (pick < 70) return pack_number(18'd0, {32'd0, $urandom} | 64'd1);
      lo[0] = 1'b1;
      return pack_number(18'($urandom_range(18'h2be68)), lo);
   endfunction

   task automatic add_number(logic [REQ_DATA_WIDTH-1:0] word);
      pending_numbers = {pending_numbers, word};
   endtask

   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      int          mismatches;
      mismatches = 0;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (req_tvalid && req_tready) begin
            expected_verdicts = {expected_verdicts, predict_primality(req_tdata)};
            numbers_sent <= numbers_sent + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            verdicts_seen <= verdicts_seen + 1;
            got = rsp_tdata[1:0];
            if (expected_verdicts.size() == 0) begin
               $error("unexpected result transfer: is_prime %0b out_of_range %0b",
                      got.is_prime, got.out_of_range);
               mismatches = mismatches + 1;
            end else begin
               want = expected_verdicts.pop_front();
               primes_seen <= primes_seen + want.is_prime;
               out_of_range_seen <= out_of_range_seen + want.out_of_range;
               if (got.is_prime !== want.is_prime) begin
                  $error("is_prime: expected %0b actual %0b", want.is_prime, got.is_prime);
                  mismatches = mismatches + 1;
               end
               if (got.out_of_range !== want.out_of_range) begin
                  $error("out_of_range: expected %0b actual %0b",
                         want.out_of_range, got.out_of_range);
                  mismatches = mismatches + 1;
               end
            end
         end
         errors <= errors + mismatches;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("tb_miller_rabin_primality_test failed");
            $finish;
         end
      end
   end

   function automatic bit calm_stretch();
      return numbers_sent >= 60 && numbers_sent < 90;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !rsp_hold && (calm_stretch() || $urandom_range(99) >= 10);
         if (!req_tvalid || req_taken) begin
            if (pending_numbers.size() != 0 && (calm_stretch() || $urandom_range(99) >= 10)) begin
               req_tdata <= pending_numbers.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   initial begin
      wait (numbers_sent >= 20);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (3000) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_number(pack_number(18'd0, 64'd0));
      add_number(pack_number(18'd0, 64'd1));
      add_number(pack_number(18'd0, 64'd2));
      add_number(pack_number(18'd0, 64'd3));
      add_number(pack_number(18'd0, 64'd4));
      add_number(pack_number(18'd0, 64'd9));
      add_number(pack_number(18'd0, 64'd999983));
      add_number(pack_number(18'd0, 64'd999999));
      add_number(pack_number(18'd0, 64'd1000000));
      add_number(pack_number(18'd0, 64'd1000001));
      add_number(pack_number(18'd0, 64'd1000002));
      add_number(pack_number(18'd0, 64'd1000003));
      add_number(pack_number(18'd0, 64'd3215031751));
      add_number(pack_number(18'd0, 64'h1fffffffffffffff));
      add_number(pack_number(18'd0, 64'hffffffffffffffc5));
      add_number(pack_number(18'd0, 64'hffffffffffffffff));
      add_number(pack_number(18'h2be69, 64'h51adc5b22410a5fb));
      add_number(pack_number(18'h2be69, 64'h51adc5b22410a5fc));
      add_number(pack_number(18'h2be69, 64'h51adc5b22410a5fd));
      add_number(pack_number(18'h2be69, 64'h51adc5b22410a5fe));
      add_number(pack_number(18'h3ffff, 64'hffffffffffffffff));
      add_number(pack_number(18'h3ffff, 64'hfffffffffffffffe));
      add_number(pack_number(18'h15555, 64'h5555555555555554));

      wait (pending_numbers.size() == 0 && !req_tvalid && expected_verdicts.size() == 0);
      @(posedge clock);
      repeat (115) add_number(random_number());

      wait (pending_numbers.size() == 0 && !req_tvalid && expected_verdicts.size() == 0);
      repeat (50) @(posedge clock);
      $display("checked %0d numbers: %0d prime, %0d out of range, long receiver stall included",
               verdicts_seen, primes_seen, out_of_range_seen);
      if (errors == 0) begin
         $display("tb_miller_rabin_primality_test passed");
      end else begin
         $display("tb_miller_rabin_primality_test failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/mrpt_pkg.sv
src/miller_rabin_primality_test.sv
src/mrpt_checker.sv
verif/tb_miller_rabin_primality_test.sv
